/* design/tmps_pkg.sv */
`timescale 1ns / 1ps

package tmps_pkg;

	// triangle geometry
	localparam int MAX_ROWS = 128;
	localparam int ADDR_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	// field widths
	localparam int VAL_W = 8;
	localparam int CFG_W = 8;
	localparam int SUM_W = 15;

	// largest sum that a full triangle of maximal values can reach
	localparam int SUM_BOUND = MAX_ROWS * ((1 << VAL_W) - 1);

	// result queue between the datapath and the output port
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = RES_PTR_W + 1;

	// position flags of one cell, worked out when the beat is taken
	typedef struct packed {
		logic first_col;
		logic last_col;
		logic top_row;
		logic last_row;
	} pos_t;

	// write port of the row buffer
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [SUM_W-1:0]  data;
	} ram_wr_t;

	// finished triangle result
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} res_t;

endpackage

/* design/tmps_row_ram.sv */
`timescale 1ns / 1ps

module tmps_row_ram (
	input  logic                          clk,
	input  tmps_pkg::ram_wr_t             wr,
	input  logic                          re,
	input  logic [tmps_pkg::ADDR_W-1:0]   raddr,
	output logic [tmps_pkg::SUM_W-1:0]    rdata
);

	logic [tmps_pkg::SUM_W-1:0] mem [tmps_pkg::MAX_ROWS];

	// one write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// one registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/tmps_res_fifo.sv */
`timescale 1ns / 1ps

module tmps_res_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tmps_pkg::res_t                  push,
	input  logic                            pop,
	output logic [tmps_pkg::RES_CNT_W-1:0]  count,
	output logic                            head_valid,
	output logic [tmps_pkg::SUM_W-1:0]      head_sum
);

	logic [tmps_pkg::SUM_W-1:0]     mem [tmps_pkg::RES_DEPTH];
	logic [tmps_pkg::RES_PTR_W-1:0] wr_ptr_q;
	logic [tmps_pkg::RES_PTR_W-1:0] rd_ptr_q;
	logic [tmps_pkg::RES_CNT_W-1:0] count_q;
	logic                           do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign count      = count_q;
	assign head_valid = (count_q != '0);
	assign head_sum   = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem[wr_ptr_q] <= push.sum;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/tmps_core.sv */
`timescale 1ns / 1ps

module tmps_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [tmps_pkg::VAL_W-1:0]    cell_value,
	input  logic                          cfg_valid,
	input  logic [tmps_pkg::CFG_W-1:0]    cfg_data,
	output logic                          cfg_ready,
	output logic                          ram_re,
	output logic [tmps_pkg::ADDR_W-1:0]   ram_raddr,
	input  logic [tmps_pkg::SUM_W-1:0]    ram_rdata,
	output tmps_pkg::ram_wr_t             ram_wr,
	output logic                          res_pending,
	output tmps_pkg::res_t                res
);

	// configuration and position state
	logic [tmps_pkg::CFG_W-1:0]  row_count_q;
	logic [tmps_pkg::ADDR_W-1:0] row_q;
	logic [tmps_pkg::ADDR_W-1:0] col_q;
	logic [tmps_pkg::ADDR_W-1:0] rows_last;
	logic                        cfg_write;

	// stage 1: buffer data arrives, sum is formed and written back
	logic                        valid_s1;
	tmps_pkg::pos_t              pos_s1;
	logic [tmps_pkg::VAL_W-1:0]  value_s1;
	logic [tmps_pkg::ADDR_W-1:0] col_s1;
	logic                        fwd_s1;
	logic [tmps_pkg::SUM_W-1:0]  fwd_sum_s1;

	logic [tmps_pkg::SUM_W-1:0]  left_parent_q;
	logic [tmps_pkg::SUM_W-1:0]  running_max_q;

	tmps_pkg::pos_t              pos;
	logic [tmps_pkg::SUM_W-1:0]  above;
	logic [tmps_pkg::SUM_W-1:0]  parent;
	logic [tmps_pkg::SUM_W:0]    sum_wide;
	logic [tmps_pkg::SUM_W-1:0]  sum;
	logic [tmps_pkg::SUM_W-1:0]  new_max;

	assign cfg_ready = !valid_s1;
	assign cfg_write = cfg_valid && cfg_ready;

	// index of the last row, row count clamped to one..MAX_ROWS
	always_comb begin
		if (row_count_q == '0) begin
			rows_last = '0;
		end else if (int'(row_count_q) > tmps_pkg::MAX_ROWS) begin
			rows_last = tmps_pkg::ADDR_W'(tmps_pkg::MAX_ROWS - 1);
		end else begin
			rows_last = tmps_pkg::ADDR_W'(row_count_q - 1'b1);
		end
	end

	// position of the incoming beat
	always_comb begin
		pos.first_col = (col_q == '0);
		pos.last_col  = (col_q == row_q);
		pos.top_row   = (row_q == '0);
		pos.last_row  = (row_q == rows_last);
	end

	// read the entry above the incoming cell
	assign ram_re    = accept;
	assign ram_raddr = col_q;

	// row buffer data, or the sum still being written by the previous beat
	assign above = fwd_s1 ? fwd_sum_s1 : ram_rdata;

	// pick the parent
	always_comb begin
		if (pos_s1.top_row) begin
			parent = '0;
		end else if (pos_s1.first_col) begin
			parent = above;
		end else if (pos_s1.last_col) begin
			parent = left_parent_q;
		end else begin
			parent = (left_parent_q > above) ? left_parent_q : above;
		end
	end

	// saturating path sum and running maximum of the last row
	always_comb begin
		sum_wide = {1'b0, parent} + (tmps_pkg::SUM_W + 1)'(value_s1);
		sum      = sum_wide[tmps_pkg::SUM_W] ? '1 : sum_wide[tmps_pkg::SUM_W-1:0];
		new_max  = (pos_s1.first_col || (sum > running_max_q)) ? sum : running_max_q;
	end

	// write-back and result
	always_comb begin
		ram_wr.en   = valid_s1;
		ram_wr.addr = col_s1;
		ram_wr.data = sum;
		res_pending = valid_s1 && pos_s1.last_row && pos_s1.last_col;
		res.valid   = res_pending;
		res.sum     = new_max;
	end

	// register, row and column counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= tmps_pkg::CFG_W'(1);
			row_q       <= '0;
			col_q       <= '0;
		end else if (cfg_write) begin
			row_count_q <= cfg_data;
			row_q       <= '0;
			col_q       <= '0;
		end else if (accept) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload, with forwarding when the read hits the entry being written
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1     <= pos;
			value_s1   <= cell_value;
			col_s1     <= col_q;
			fwd_s1     <= valid_s1 && (col_s1 == col_q);
			fwd_sum_s1 <= sum;
		end
	end

	// left parent and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_parent_q <= '0;
			running_max_q <= '0;
		end else if (cfg_write) begin
			left_parent_q <= '0;
			running_max_q <= '0;
		end else if (valid_s1) begin
			left_parent_q <= pos_s1.last_col ? '0 : above;
			if (pos_s1.last_row) begin
				running_max_q <= pos_s1.last_col ? '0 : new_max;
			end
		end
	end

endmodule

/* design/triangle_max_path_sum.sv */
`timescale 1ns / 1ps

// Maximum path sum of a number triangle, streamed top-down. Values enter one
// beat per clock while cell_stall is low, in row-major order (row i holds i+1
// values); row_count sets the rows per triangle (zero means one, above 128
// means 128). The row buffer has one read and one write port: the entry above
// a cell is read as the beat is taken and the updated sum is written back the
// next cycle, with the write forwarded when the following beat reads the same
// entry. With no earlier result queued, the sum of a triangle passes the stage-1
// register and then the result queue before it appears on max_sum; a four-deep
// result queue lets values keep flowing while results wait. row_count may be
// written when no beat is in flight; a write abandons a triangle in progress.
// The row buffer needs no clearing after reset.
module triangle_max_path_sum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cell_valid,
	output logic                          cell_stall,
	input  logic [tmps_pkg::VAL_W-1:0]    cell_value,
	output logic                          sum_valid,
	input  logic                          sum_stall,
	output logic [tmps_pkg::SUM_W-1:0]    max_sum,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tmps_pkg::CFG_W-1:0]    row_count
);

	logic                             accept;
	logic                             res_pending;
	tmps_pkg::res_t                   res;
	logic [tmps_pkg::RES_CNT_W-1:0]   res_count;
	logic                             ram_re;
	logic [tmps_pkg::ADDR_W-1:0]      ram_raddr;
	logic [tmps_pkg::SUM_W-1:0]       ram_rdata;
	tmps_pkg::ram_wr_t                ram_wr;

	// hold off input when the result queue could overflow
	assign cell_stall = ((tmps_pkg::RES_CNT_W + 1)'(res_count)
		+ (tmps_pkg::RES_CNT_W + 1)'(res_pending))
		> (tmps_pkg::RES_CNT_W + 1)'(tmps_pkg::RES_DEPTH - 1);
	assign accept = cell_valid && !cell_stall;

	tmps_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cell_value  (cell_value),
		.cfg_valid   (cfg_valid),
		.cfg_data    (row_count),
		.cfg_ready   (cfg_ready),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.ram_wr      (ram_wr),
		.res_pending (res_pending),
		.res         (res)
	);

	tmps_row_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tmps_res_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res),
		.pop        (!sum_stall),
		.count      (res_count),
		.head_valid (sum_valid),
		.head_sum   (max_sum)
	);

endmodule

/* design/tmps_checker.sv */
`timescale 1ns / 1ps

module tmps_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cell_valid,
	input  logic                          cell_stall,
	input  logic                          sum_valid,
	input  logic                          sum_stall,
	input  logic [tmps_pkg::SUM_W-1:0]    max_sum
);

	// a stalled result beat stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> sum_valid && $stable(max_sum))
		else $error("result beat changed while stalled");

	// a path sum never exceeds the largest full-triangle total
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |-> (int'(max_sum) <= tmps_pkg::SUM_BOUND))
		else $error("max_sum above largest possible path sum");

	// a new result follows an input beat taken ahead of the stage-1 register and the result queue
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sum_valid) |-> $past(cell_valid && !cell_stall, 2))
		else $error("result without a matching input beat");

	// with no result queued the input is never held off
	assert property (@(posedge clk) disable iff (!arst_n)
		!sum_valid |-> !cell_stall)
		else $error("input stalled with empty result queue");

endmodule

bind triangle_max_path_sum tmps_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_valid (cell_valid),
	.cell_stall (cell_stall),
	.sum_valid  (sum_valid),
	.sum_stall  (sum_stall),
	.max_sum    (max_sum)
);

/* bench/tmps_path_check.sv */
`timescale 1ns / 1ps

module tmps_path_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cell_valid,
	input  logic                       cell_stall,
	input  logic [tmps_pkg::VAL_W-1:0] cell_value,
	input  logic                       sum_valid,
	input  logic                       sum_stall,
	input  logic [tmps_pkg::SUM_W-1:0] max_sum,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [tmps_pkg::CFG_W-1:0] row_count,
	output int                         errors,
	output int                         pending
);

	localparam logic [tmps_pkg::SUM_W-1:0] SUM_LIMIT = {tmps_pkg::SUM_W{1'b1}};

	// predicted triangle state
	logic [tmps_pkg::SUM_W-1:0] path_best [tmps_pkg::MAX_ROWS];
	logic [tmps_pkg::CFG_W-1:0] rows_reg;
	int                         row_at;
	int                         col_at;
	logic [tmps_pkg::SUM_W-1:0] left_sum;
	logic [tmps_pkg::SUM_W-1:0] peak_sum;

	// sums still owed by the block, oldest first
	logic [tmps_pkg::SUM_W-1:0] sums_due [$];
	logic [tmps_pkg::SUM_W-1:0] want;
	int                         fail_count;

	task automatic restart_triangle();
		row_at = 0;
		col_at = 0;
		left_sum = '0;
		peak_sum = '0;
	endtask

	// fold one value into the best-sum row, queue the maximum on the final value
	task automatic take_cell(input logic [tmps_pkg::VAL_W-1:0] v);
		int                         rows_now;
		int                         r;
		int                         c;
		logic [tmps_pkg::SUM_W-1:0] above;
		logic [tmps_pkg::SUM_W-1:0] parent;
		logic [tmps_pkg::SUM_W:0]   total;
		logic [tmps_pkg::SUM_W-1:0] s;
		rows_now = (rows_reg == 0) ? 1
			: ((rows_reg > tmps_pkg::MAX_ROWS) ? tmps_pkg::MAX_ROWS : int'(rows_reg));
		r = row_at;
		c = col_at;
		if (r >= rows_now)
			r = rows_now - 1;
		if (c > r)
			c = r;
		above = path_best[c];
		parent = '0;
		if (r > 0) begin
			if (c == 0)
				parent = above;
			else if (c == r)
				parent = left_sum;
			else
				parent = (left_sum > above) ? left_sum : above;
		end
		total = {1'b0, parent} + v;
		s = (total > SUM_LIMIT) ? SUM_LIMIT : total[tmps_pkg::SUM_W-1:0];
		left_sum = above;
		path_best[c] = s;
		if (r == rows_now - 1 && (c == 0 || s > peak_sum))
			peak_sum = s;
		if (c == r) begin
			if (r == rows_now - 1) begin
				sums_due = {sums_due, peak_sum};
				restart_triangle();
			end else begin
				row_at = r + 1;
				col_at = 0;
				left_sum = '0;
			end
		end else begin
			row_at = r;
			col_at = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = 8'd1;
			for (int i = 0; i < tmps_pkg::MAX_ROWS; i++)
				path_best[i] = '0;
			restart_triangle();
			sums_due.delete();
		end else begin
			// result beat against the oldest owed sum
			if (sum_valid && !sum_stall) begin
				if (sums_due.size() == 0) begin
					$error("max_sum: no result expected, actual %0d", max_sum);
					fail_count++;
				end else begin
					want = sums_due.pop_front();
					if (max_sum !== want) begin
						$error("max_sum: expected %0d, actual %0d", want, max_sum);
						fail_count++;
					end
				end
			end
			// register write drops any triangle in progress
			if (cfg_valid && cfg_ready) begin
				rows_reg = row_count;
				restart_triangle();
			end
			if (cell_valid && !cell_stall)
				take_cell(cell_value);
		end
		errors <= fail_count;
		pending <= sums_due.size();
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int SETTLE       = 8;
	localparam int HOLD_LEN     = 400;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cell_valid = 1'b0;
	logic                       cell_stall;
	logic [tmps_pkg::VAL_W-1:0] cell_value = '0;
	logic                       sum_valid;
	logic                       sum_stall = 1'b0;
	logic [tmps_pkg::SUM_W-1:0] max_sum;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [tmps_pkg::CFG_W-1:0] row_count = '0;

	int errors;
	int pending;
	int cycle_count = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int hold_count = 0;
	int hold_seen = 0;
	int hold_left = 0;

	triangle_max_path_sum dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_value (cell_value),
		.sum_valid  (sum_valid),
		.sum_stall  (sum_stall),
		.max_sum    (max_sum),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.row_count  (row_count)
	);

	tmps_path_check check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_value (cell_value),
		.sum_valid  (sum_valid),
		.sum_stall  (sum_stall),
		.max_sum    (max_sum),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.row_count  (row_count),
		.errors     (errors),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	// run time guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stall, or a long hold when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			sum_stall <= 1'b0;
		end else begin
			if (hold_seen != hold_count) begin
				hold_seen = hold_count;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				sum_stall <= 1'b1;
			end else begin
				sum_stall <= ($urandom_range(99) < recv_pct);
			end
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_pct = 0;  recv_pct = 0;  end
			1: begin send_pct = 53; recv_pct = 0;  end
			2: begin send_pct = 0;  recv_pct = 53; end
			default: begin send_pct = 13; recv_pct = 13; end
		endcase
	endtask

	// one value beat, with random idle cycles ahead of it
	task automatic send_cell(input logic [tmps_pkg::VAL_W-1:0] v);
		while ($urandom_range(99) < send_pct) begin
			cell_valid <= 1'b0;
			@(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_value <= v;
		do
			@(posedge clk);
		while (cell_stall);
	endtask

	// stop offering beats and wait until every owed sum has come out
	task automatic drain();
		cell_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_rows(input logic [tmps_pkg::CFG_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		row_count <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic int triangle_cells(input int rows);
		int eff;
		eff = (rows == 0) ? 1
			: ((rows > tmps_pkg::MAX_ROWS) ? tmps_pkg::MAX_ROWS : rows);
		return eff * (eff + 1) / 2;
	endfunction

	// values leaning toward the extremes now and then
	function automatic logic [tmps_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return tmps_pkg::VAL_W'($urandom_range(255));
		endcase
	endfunction

	initial begin
		int phase;
		int rows;
		int sel;
		int cells;
		int count;
		int random_sent;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-row triangles at the reset setting
		set_idling(0);
		send_cell(8'd0);
		send_cell(8'd255);
		send_cell(8'd128);
		send_cell(8'd127);
		// zero rows behaves as one
		set_rows(8'd0);
		send_cell(8'd1);
		send_cell(8'd254);
		// three rows: edge parents and middle choice
		set_rows(8'd3);
		send_cell(8'd255);
		send_cell(8'd0);
		send_cell(8'd255);
		send_cell(8'd255);
		send_cell(8'd1);
		send_cell(8'd255);
		send_cell(8'd1);
		send_cell(8'd2);
		send_cell(8'd3);
		send_cell(8'd4);
		send_cell(8'd5);
		send_cell(8'd6);
		// triangle cut short by a register write
		set_rows(8'd2);
		send_cell(8'd7);
		send_cell(8'd9);
		set_rows(8'd2);
		send_cell(8'd100);
		send_cell(8'd200);
		send_cell(8'd50);

		// result side held off while beats keep coming
		set_rows(8'd1);
		hold_count <= hold_count + 1;
		repeat (80) send_cell(pick_value());

		// larger triangle, all maximal values
		set_rows(8'd24);
		repeat (triangle_cells(24)) send_cell(8'd255);

		// random triangles, mostly small, a few cut short
		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			sel = $urandom_range(19);
			if (sel == 0)
				rows = $urandom_range(17, 24);
			else if (sel < 4)
				rows = $urandom_range(7, 16);
			else
				rows = $urandom_range(1, 6);
			set_rows(rows[tmps_pkg::CFG_W-1:0]);
			set_idling(phase % 4);
			cells = triangle_cells(rows);
			count = (sel < 4) ? cells : $urandom_range(1, 6) * cells;
			if ($urandom_range(3) == 0)
				count += $urandom_range(cells - 1);
			repeat (count) send_cell(pick_value());
			random_sent += count;
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
design/tmps_pkg.sv
design/tmps_row_ram.sv
design/tmps_res_fifo.sv
design/tmps_core.sv
design/triangle_max_path_sum.sv
design/tmps_checker.sv
bench/tmps_path_check.sv
bench/tb.sv
